[hw/rtl/wrbs_pkg.sv]
// Shared types, codes and defaults for the weighted random branch select core.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package wrbs_pkg;

   localparam int MAX_BRANCHES_DEF = 64;
   localparam int SPACE_BITS_DEF   = 48;

   // fixed field widths of the request and response
   localparam int SPACE_W  = 48;
   localparam int RND_W    = 64;
   localparam int STATUS_W = 2;
   localparam int CHOSEN_W = 6;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_ENOENT = 2'd1,
      ST_EROFS  = 2'd2,
      ST_ENOSPC = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_DECIDE,
      S_DIV,
      S_WALK_RD,
      S_WALK_CHK,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic div_start;
      logic div_step;
      logic walk_rd;
      logic walk_chk;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic sum_zero;
      logic div_last;
      logic walk_done;
      logic out_free;
   } stat_type;

   // read-only outranks no-space, which outranks not-found
   function automatic logic [1:0] err_rank(status_type e);
      logic [1:0] r;
      r = 2'd0;
      if (e == ST_EROFS) begin
         r = 2'd2;
      end else if (e == ST_ENOSPC) begin
         r = 2'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/wrbs_ctrl.sv]
// Sequencer for the branch select core: load, decide, divide, walk, emit.
// Depends on wrbs_pkg for the state, command and status types.
`default_nettype none

module wrbs_ctrl
   import wrbs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   input  wire logic     req_tlast,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.count_zero || stat.sum_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            cmd.walk_rd = 1'b1;
            state_in    = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            cmd.walk_chk = 1'b1;
            state_in     = stat.walk_done ? S_EMIT : S_WALK_RD;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/wrbs_dp.sv]
// Datapath: branch filter, weight memory, restoring modulo unit, prefix walk
// and response register. Depends on wrbs_pkg; driven by wrbs_ctrl commands.
`default_nettype none

module wrbs_dp
   import wrbs_pkg::*;
#(
   parameter int MAX_BRANCHES = MAX_BRANCHES_DEF,
   parameter int SPACE_BITS   = SPACE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   input  wire logic               not_writable_mark,
   input  wire logic               parent_exists,
   input  wire logic               info_ok,
   input  wire logic               fs_readonly,
   input  wire logic [SPACE_W-1:0] space_avail,
   input  wire logic [SPACE_W-1:0] min_free_space,
   input  wire logic [RND_W-1:0]   random_word,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int W      = (SPACE_BITS < SPACE_W) ? SPACE_BITS : SPACE_W;
   localparam int IDX_W  = $clog2(MAX_BRANCHES);
   localparam int CNT_W  = $clog2(MAX_BRANCHES + 1);
   localparam int SUM_W  = W + CNT_W;
   localparam int DCNT_W = $clog2(RND_W + 1);
   localparam int WORD_W = W + IDX_W;

   logic [WORD_W-1:0] mem [MAX_BRANCHES];

   logic [CNT_W-1:0]  branch_ff, elig_ff;
   logic [SUM_W-1:0]  sum_ff;
   status_type        err_ff;
   logic [RND_W-1:0]  rnd_ff;
   logic [RND_W-1:0]  quot_ff;
   logic [SUM_W-1:0]  rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [SUM_W-1:0]  run_ff;
   logic [CNT_W-1:0]  k_ff;
   logic [WORD_W-1:0] rd_word_ff;
   status_type        res_status_ff;
   logic [IDX_W-1:0]  res_chosen_ff;
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // record filter
   logic [W-1:0] avail, minfree;
   logic         in_range, eligible;
   status_type   rej_code;

   always_comb begin
      avail    = space_avail[W-1:0];
      minfree  = min_free_space[W-1:0];
      in_range = branch_ff < CNT_W'(MAX_BRANCHES);
      eligible = 1'b0;
      rej_code = ST_ENOENT;
      if (not_writable_mark) begin
         rej_code = ST_EROFS;
      end else if (!parent_exists || !info_ok) begin
         rej_code = ST_ENOENT;
      end else if (fs_readonly) begin
         rej_code = ST_EROFS;
      end else if (avail < minfree) begin
         rej_code = ST_ENOSPC;
      end else begin
         eligible = 1'b1;
      end
   end

   // modulo step
   logic [SUM_W:0] rem_shift, rem_next;
   always_comb begin
      rem_shift = {rem_ff, quot_ff[RND_W-1]};
      rem_next  = rem_shift;
      if (rem_shift >= {1'b0, sum_ff}) begin
         rem_next = rem_shift - {1'b0, sum_ff};
      end
   end

   // walk step
   logic [W-1:0]     walk_w;
   logic [IDX_W-1:0] walk_idx;
   logic [SUM_W-1:0] run_next;
   logic [CNT_W-1:0] k_next;
   logic             walk_hit;
   always_comb begin
      walk_w   = rd_word_ff[W-1:0];
      walk_idx = rd_word_ff[W +: IDX_W];
      run_next = run_ff + SUM_W'(walk_w);
      k_next   = k_ff + CNT_W'(1);
      walk_hit = run_next > rem_ff;
   end

   always_comb begin
      stat.count_zero = (elig_ff == '0);
      stat.sum_zero   = (sum_ff == '0);
      stat.div_last   = (dcnt_ff == DCNT_W'(1));
      stat.walk_done  = walk_hit || (k_next == elig_ff);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // set bookkeeping
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         branch_ff <= '0;
         elig_ff   <= '0;
         sum_ff    <= '0;
         err_ff    <= ST_ENOENT;
      end else if (cmd.load && in_range) begin
         branch_ff <= branch_ff + CNT_W'(1);
         if (eligible) begin
            elig_ff <= elig_ff + CNT_W'(1);
            sum_ff  <= sum_ff + SUM_W'(avail);
         end else if (err_rank(rej_code) >= err_rank(err_ff)) begin
            err_ff <= rej_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && in_range && eligible) begin
         mem[elig_ff[IDX_W-1:0]] <= {branch_ff[IDX_W-1:0], avail};
      end
      if (cmd.walk_rd) begin
         rd_word_ff <= mem[k_ff[IDX_W-1:0]];
      end
   end

   // division and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rnd_ff <= random_word;
      end
      if (cmd.div_start) begin
         quot_ff <= rnd_ff;
         rem_ff  <= '0;
         dcnt_ff <= DCNT_W'(RND_W);
         run_ff  <= '0;
         k_ff    <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_ff << 1;
         rem_ff  <= rem_next[SUM_W-1:0];
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
      end else if (cmd.walk_chk) begin
         run_ff <= run_next;
         k_ff   <= k_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         res_chosen_ff <= '0;
         if (elig_ff == '0) begin
            res_status_ff <= err_ff;
         end else if (sum_ff == '0) begin
            res_status_ff <= ST_ENOSPC;
         end else begin
            res_status_ff <= ST_OK;
         end
      end else if (cmd.walk_chk && stat.walk_done) begin
         res_chosen_ff <= walk_idx;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {CHOSEN_W'(res_chosen_ff), res_status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[hw/rtl/weighted_random_branch_select_core.sv]
// Top level of the weighted random branch select core: unpacks the request
// stream and joins wrbs_ctrl and wrbs_dp. Depends on wrbs_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  req     | in        | req_tvalid / req_tready | req_tdata (branch record), tlast
//  rsp     | out       | rsp_tvalid / rsp_tready | rsp_tdata (status, chosen_branch)
//
// Records within a set can stream back to back; after the last record no new
// record is taken until the set's result is emitted. The core decides, runs
// the modulo unit one bit per cycle over the 64-bit random word, then walks the
// prefix sums, reading the single-port weight memory and checking the entry in
// turn for each walked eligible entry, and emits. A set with no usable weight
// skips the modulo and walk. Reset is synchronous and clears all set
// bookkeeping; the weight memory is not cleared. A stalled response sits in
// the output register while the next set's records are accepted.
`default_nettype none

module weighted_random_branch_select_core
   import wrbs_pkg::*;
#(
   parameter int MAX_BRANCHES = MAX_BRANCHES_DEF,
   parameter int SPACE_BITS   = SPACE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [0] not_writable_mark, [1] parent_exists, [2] info_ok, [3] fs_readonly,
   // [51:4] space_avail, [99:52] min_free_space, [163:100] random_word, rest zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,   // last_branch
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] status, [7:2] chosen_branch
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   cmd_type  cmd;
   stat_type stat;

   // request field offsets within tdata
   localparam int NW_POS   = 0;
   localparam int PAR_POS  = 1;
   localparam int INFO_POS = 2;
   localparam int RO_POS   = 3;
   localparam int AV_POS   = 4;
   localparam int MIN_POS  = AV_POS + SPACE_W;
   localparam int RND_POS  = MIN_POS + SPACE_W;

   wrbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wrbs_dp #(
      .MAX_BRANCHES (MAX_BRANCHES),
      .SPACE_BITS   (SPACE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .not_writable_mark (req_tdata[NW_POS]),
      .parent_exists     (req_tdata[PAR_POS]),
      .info_ok           (req_tdata[INFO_POS]),
      .fs_readonly       (req_tdata[RO_POS]),
      .space_avail       (req_tdata[AV_POS +: SPACE_W]),
      .min_free_space    (req_tdata[MIN_POS +: SPACE_W]),
      .random_word       (req_tdata[RND_POS +: RND_W]),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tdata         (rsp_tdata)
   );

endmodule

`default_nettype wire

[tb/wrbs_pick_checker.sv]
`timescale 1ns / 1ps
// Checker for the weighted random branch select core: watches the request and
// response streams, predicts each set's pick and compares. Depends on wrbs_pkg.
module wrbs_pick_checker
   import wrbs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned                fail_count,
   output int unsigned                picks_pending,
   output int unsigned                records_taken,
   output int unsigned                records_dropped,
   output int unsigned                results_checked,
   output int unsigned                branches_picked
);

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      status_type          status;
      logic [CHOSEN_W-1:0] branch;
   } pick_t;

   // per-set bookkeeping of the predictor
   logic [SPACE_W-1:0]  weight_mem [MAX_BRANCHES_DEF];
   logic [CHOSEN_W-1:0] slot_mem   [MAX_BRANCHES_DEF];
   int unsigned         eligible_n;
   int unsigned         seen_n;
   logic [63:0]         weight_total;
   status_type          err_acc;
   pick_t               expected_picks [$];

   function automatic int unsigned err_level(status_type e);
      case (e)
         ST_EROFS:  return 2;
         ST_ENOSPC: return 1;
         default:   return 0;
      endcase
   endfunction

   // keep the stronger error; ties go to the newer one
   function automatic void fold_reject(status_type e);
      if (err_level(e) >= err_level(err_acc)) begin
         err_acc = e;
      end
   endfunction

   // draw threshold = rnd mod total, then walk the running sum
   function automatic pick_t spin_wheel(logic [RND_W-1:0] rnd);
      pick_t       p;
      logic [63:0] thr;
      logic [63:0] run;
      bit          hit;
      p.status = ST_OK;
      p.branch = '0;
      run = '0;
      hit = 1'b0;
      if (eligible_n == 0) begin
         p.status = err_acc;
      end else if (weight_total == 0) begin
         p.status = ST_ENOSPC;
      end else begin
         thr = rnd % weight_total;
         for (int k = 0; k < eligible_n && !hit; k++) begin
            if (weight_mem[k] != 0) begin
               run += 64'(weight_mem[k]);
               if (run > thr) begin
                  p.branch = slot_mem[k];
                  hit = 1'b1;
               end
            end
         end
         if (!hit) begin
            p.branch = slot_mem[eligible_n-1];
         end
      end
      return p;
   endfunction

   task automatic flag_mismatch(string msg);
      if (fail_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      logic [SPACE_W-1:0] avail;
      logic [SPACE_W-1:0] floor_space;
      logic [RND_W-1:0]   rnd;
      pick_t              got;
      pick_t              want;
      if (reset) begin
         eligible_n      = 0;
         seen_n          = 0;
         weight_total    = '0;
         err_acc         = ST_ENOENT;
         expected_picks.delete();
         fail_count      = 0;
         picks_pending   = 0;
         records_taken   = 0;
         records_dropped = 0;
         results_checked = 0;
         branches_picked = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            avail       = req_tdata[4 +: SPACE_W];
            floor_space = req_tdata[4+SPACE_W +: SPACE_W];
            rnd         = req_tdata[4+2*SPACE_W +: RND_W];
            if (seen_n < MAX_BRANCHES_DEF) begin
               if (req_tdata[0]) begin
                  fold_reject(ST_EROFS);
               end else if (!req_tdata[1] || !req_tdata[2]) begin
                  fold_reject(ST_ENOENT);
               end else if (req_tdata[3]) begin
                  fold_reject(ST_EROFS);
               end else if (avail < floor_space) begin
                  fold_reject(ST_ENOSPC);
               end else begin
                  weight_mem[eligible_n] = avail;
                  slot_mem[eligible_n]   = CHOSEN_W'(seen_n);
                  eligible_n++;
                  weight_total += 64'(avail);
               end
               seen_n++;
               records_taken++;
            end else begin
               // past the branch limit: no store, no error update
               records_dropped++;
            end
            if (req_tlast) begin
               expected_picks.insert(expected_picks.size(), spin_wheel(rnd));
               eligible_n   = 0;
               seen_n       = 0;
               weight_total = '0;
               err_acc      = ST_ENOENT;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[STATUS_W-1:0]);
            got.branch = rsp_tdata[STATUS_W +: CHOSEN_W];
            if (expected_picks.size() == 0) begin
               flag_mismatch($sformatf("unexpected response %h", rsp_tdata));
            end else begin
               want = expected_picks.pop_front();
               results_checked++;
               if (want.status == ST_OK) begin
                  branches_picked++;
               end
               if (got.status !== want.status) begin
                  flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
               end
               if (got.branch !== want.branch) begin
                  flag_mismatch($sformatf("chosen_branch %0d, want %0d",
                     got.branch, want.branch));
               end
            end
         end
         picks_pending = expected_picks.size();
      end
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench top for weighted_random_branch_select_core: drives branch-record
// sets, paces the response side and gives the verdict. Needs wrbs_pkg and
// wrbs_pick_checker.
module tb;
   import wrbs_pkg::*;

   localparam int HOLD_CYCLES  = 400;    // long response hold-off
   localparam int RANDOM_ITEMS = 1000;   // counted records in the random part
   localparam int DRAIN_CYCLES = 300;

   typedef enum int {
      REC_OPEN, REC_NO_CREATE, REC_NO_PARENT, REC_INFO_FAIL, REC_RO_MOUNT, REC_LOW_SPACE
   } rec_kind_t;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

   typedef struct {
      logic               no_create;
      logic               parent_ok;
      logic               info_good;
      logic               ro_mount;
      logic [SPACE_W-1:0] avail;
      logic [SPACE_W-1:0] floor_space;
      logic [RND_W-1:0]   rnd;
      logic               is_last;
   } branch_rec_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   // [0] not_writable_mark, [1] parent_exists, [2] info_ok, [3] fs_readonly,
   // [51:4] space_avail, [99:52] min_free_space, [163:100] random_word, rest zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;   // last_branch
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [1:0] status, [7:2] chosen_branch
   wire [RSP_DATA_W-1:0]  rsp_tdata;

   int unsigned fail_count;
   int unsigned picks_pending;
   int unsigned records_taken;
   int unsigned records_dropped;
   int unsigned results_checked;
   int unsigned branches_picked;

   int burst_left = 0;   // requests left in the current sender burst
   int hold_asks  = 0;   // long holds asked for by the stimulus
   int holds_done = 0;   // long holds started by the response side
   int items_sent = 0;   // counted records of the random part

   weighted_random_branch_select_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wrbs_pick_checker pick_chk (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .picks_pending   (picks_pending),
      .records_taken   (records_taken),
      .records_dropped (records_dropped),
      .results_checked (results_checked),
      .branches_picked (branches_picked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #8_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // weights: zero, tiny, full-scale, 16-bit or, most often, fully random
   function automatic logic [SPACE_W-1:0] rand_space();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2, 3: return SPACE_W'($urandom_range(1, 20));
         4:       return '1;
         5:       return SPACE_W'($urandom_range(0, 65535));
         default: return w[SPACE_W-1:0];
      endcase
   endfunction

   function automatic logic [RND_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return RND_W'($urandom_range(0, 100));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic branch_rec_t rec_of(logic nc, logic par, logic inf, logic ro,
                                          logic [SPACE_W-1:0] avail,
                                          logic [SPACE_W-1:0] floor_space,
                                          logic [RND_W-1:0] rnd, logic is_last);
      branch_rec_t r;
      r.no_create   = nc;
      r.parent_ok   = par;
      r.info_good   = inf;
      r.ro_mount    = ro;
      r.avail       = avail;
      r.floor_space = floor_space;
      r.rnd         = rnd;
      r.is_last     = is_last;
      return r;
   endfunction

   // build one record of the given kind; flags below the deciding one stay random
   function automatic branch_rec_t make_record(rec_kind_t kind, logic is_last);
      branch_rec_t r;
      logic [63:0] span;
      r = rec_of(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 rand_space(), rand_space(), rand_word(), is_last);
      case (kind)
         REC_OPEN: begin
            r.no_create = 1'b0;
            r.parent_ok = 1'b1;
            r.info_good = 1'b1;
            r.ro_mount  = 1'b0;
            case ($urandom_range(0, 3))
               0: r.floor_space = '0;
               1: r.floor_space = r.avail;
               default: begin
                  span = {$urandom, $urandom} % (64'(r.avail) + 64'd1);
                  r.floor_space = span[SPACE_W-1:0];
               end
            endcase
         end
         REC_NO_CREATE: begin
            r.no_create = 1'b1;
         end
         REC_NO_PARENT: begin
            r.no_create = 1'b0;
            r.parent_ok = 1'b0;
         end
         REC_INFO_FAIL: begin
            r.no_create = 1'b0;
            r.parent_ok = 1'b1;
            r.info_good = 1'b0;
         end
         REC_RO_MOUNT: begin
            r.no_create = 1'b0;
            r.parent_ok = 1'b1;
            r.info_good = 1'b1;
            r.ro_mount  = 1'b1;
         end
         default: begin
            // below the minimum: avail strictly under floor_space
            r.no_create = 1'b0;
            r.parent_ok = 1'b1;
            r.info_good = 1'b1;
            r.ro_mount  = 1'b0;
            if (r.floor_space == 0) begin
               r.floor_space = SPACE_W'(1);
            end
            span = {$urandom, $urandom} % 64'(r.floor_space);
            r.avail = span[SPACE_W-1:0];
         end
      endcase
      return r;
   endfunction

   function automatic rec_kind_t pick_kind(bit reject_heavy);
      int roll;
      roll = reject_heavy ? $urandom_range(6, 10) : $urandom_range(0, 10);
      case (roll)
         6:       return REC_NO_CREATE;
         7:       return REC_NO_PARENT;
         8:       return REC_INFO_FAIL;
         9:       return REC_RO_MOUNT;
         10:      return REC_LOW_SPACE;
         default: return REC_OPEN;
      endcase
   endfunction

   // Offer one request at the falling edge and hold it until accepted. Bursts of
   // random length are separated by random gaps; a zero gap keeps valid high.
   task automatic send_record(branch_rec_t r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-4-2*SPACE_W-RND_W){1'b0}}, r.rnd, r.floor_space,
                     r.avail, r.ro_mount, r.info_good, r.parent_ok, r.no_create};
      req_tlast  <= r.is_last;
      do @(posedge clock); while (!req_tready);
   endtask

   // one set of n records, the last one marked; records past the limit don't count
   task automatic send_set(int n, bit reject_heavy);
      rec_kind_t kind;
      for (int i = 0; i < n; i++) begin
         kind = pick_kind(reject_heavy);
         send_record(make_record(kind, i == n - 1));
         if (i < MAX_BRANCHES_DEF) begin
            items_sent++;
         end
      end
   endtask

   // Response side: switch between pacing modes every so often, and run one
   // long hold-off, counted here, whenever the stimulus asks for it.
   initial begin : rsp_pacing
      int       mode_left;
      int       hold_left;
      rx_mode_t mode;
      mode_left = 0;
      hold_left = 0;
      mode      = RX_ALWAYS;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_t'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               RX_ALWAYS: rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int n;
      int roll;
      int set_no;
      int big_sets;
      set_no   = 0;
      big_sets = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lone eligible branch at full scale, largest random word
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, '1, '0, '1, 1'b1));
      // each single rejection reason on its own
      send_record(rec_of(1'b1, 1'b1, 1'b1, 1'b0, 48'd20, '0, 64'd7, 1'b1));
      send_record(rec_of(1'b0, 1'b0, 1'b1, 1'b0, 48'd20, '0, 64'd7, 1'b1));
      send_record(rec_of(1'b0, 1'b1, 1'b0, 1'b0, 48'd20, '0, 64'd7, 1'b1));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b1, 48'd20, '0, 64'd7, 1'b1));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, 48'd5, 48'd6, 64'd7, 1'b1));
      // no-space outranks a later not-found
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, 48'd1, '1, '0, 1'b0));
      send_record(rec_of(1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b1));
      // read-only outranks both, also when no-space comes after it
      send_record(rec_of(1'b0, 1'b1, 1'b0, 1'b0, 48'd3, '0, '0, 1'b0));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b1, 48'd3, '0, '0, 1'b0));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, '0, 48'd9, '1, 1'b1));
      // every eligible weight zero: no space
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, '0, '0, 64'd3, 1'b0));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, '0, '0, 64'd3, 1'b1));
      // zero weights are skipped in the walk
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, '0, '0, '1, 1'b0));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, 48'd7, '0, '1, 1'b0));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, '0, '0, '1, 1'b1));
      // space equal to the minimum is eligible; threshold zero picks the first
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, 48'd5, 48'd5, '0, 1'b0));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, '1, '1, '0, 1'b1));
      // one eligible branch between rejections
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, 48'd2, 48'd3, '0, 1'b0));
      send_record(rec_of(1'b0, 1'b1, 1'b1, 1'b0, '1, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0));
      send_record(rec_of(1'b1, 1'b0, 1'b0, 1'b1, '1, '1, '1, 1'b1));

      // random sets: mostly short, some medium, a few near or past the branch limit
      while (items_sent < RANDOM_ITEMS) begin
         if (set_no == 8) begin
            hold_asks++;   // stall responses while short sets keep coming
         end
         roll = $urandom_range(0, 99);
         if (set_no == 3 || (roll == 0 && big_sets < 4)) begin
            n = MAX_BRANCHES_DEF - 2 + $urandom_range(0, 10);
            big_sets++;
         end else if (roll < 75) begin
            n = $urandom_range(1, 6);
         end else begin
            n = $urandom_range(7, 20);
         end
         send_set(n, $urandom_range(0, 6) == 0);
         set_no++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // drain: wait for every predicted pick, then watch for strays
      while (picks_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d branch records in %0d sets, %0d of them past the limit",
               records_taken + records_dropped, results_checked, records_dropped);
      $display("%0d responses checked, %0d with a branch picked, one long response hold",
               results_checked, branches_picked);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
